/* hdl/cms_pkg.sv */
`timescale 1ns / 1ps
package cms_pkg;
  localparam int unsigned Window = 7;
  localparam int unsigned NChan = 3;
  localparam int unsigned FillW = $clog2(Window + 1);
  localparam int unsigned SlotW = $clog2(NChan * Window);
  localparam int unsigned MemDepth = NChan * Window;
  localparam logic [16:0] LevelSat = 17'd128000;
  localparam logic [25:0] Dividend = 26'd32768000;
  // ceil(2^21 / 3) and ceil(2^23 / 9), exact for the operand ranges in use
  localparam logic [19:0] Recip3 = 20'd699051;
  localparam logic [19:0] Recip9 = 20'd932068;

  localparam logic [2:0] RegAlpha = 3'd0;
  localparam logic [2:0] RegWhiteSpread = 3'd1;
  localparam logic [2:0] RegWhiteMean = 3'd2;
  localparam logic [2:0] RegBlackSpread = 3'd3;
  localparam logic [2:0] RegBlackMean = 3'd4;

  localparam logic [1:0] ClassWhite = 2'd0;
  localparam logic [1:0] ClassBlack = 2'd1;
  localparam logic [1:0] ClassOther = 2'd2;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [16:0] white_spread_max;
    logic [16:0] white_mean_min;
    logic [16:0] black_spread_max;
    logic [16:0] black_mean_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [15:0] period;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  colour_class;
    logic [16:0] red_level;
    logic [16:0] green_level;
    logic [16:0] blue_level;
    logic [16:0] mean_level;
    logic [16:0] spread_level;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle, StRead, StSort, StEma, StDiv, StSum, StSqrt, StClass, StOut
  } state_e;
endpackage

/* hdl/cms_stream_if.sv */
`timescale 1ns / 1ps
interface cms_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/cms_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle: 26-bit dividend over 24-bit divisor
module cms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [16:0] level_o
);
  import cms_pkg::*;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [25:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] dvs_q, dvs_d;
  logic [26:0] num;
  logic [24:0] trial;
  logic        done_q, done_d;

  assign num = {1'b0, Dividend} + {4'd0, divisor_i[23:1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    done_d = 1'b0;
    trial = {rem_q[23:0], quo_q[25]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 5'd26;
      quo_d = num[25:0];
      rem_d = {24'd0, num[26]};
      dvs_d = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[24:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign level_o = (dvs_q == 24'd0 || quo_q > {9'd0, LevelSat}) ? LevelSat : quo_q[16:0];
endmodule

/* hdl/cms_sqrt.sv */
`timescale 1ns / 1ps
// bit-pair integer square root, one result bit per cycle
module cms_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] rad_i,
  output logic        done_o,
  output logic [19:0] root_o
);
  import cms_pkg::*;
  logic [39:0] x_q, x_d;
  logic [39:0] res_q, res_d;
  logic [39:0] bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d = x_q;
    res_d = res_q;
    bit_d = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = rad_i;
      res_d = '0;
      bit_d = 40'd1 << 38;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q >= res_q + bit_q) begin
        x_d = x_q - (res_q + bit_q);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[19:0];
endmodule

/* hdl/color_median_smooth_classifier.sv */
`timescale 1ns / 1ps
// Median filter, exponential smoother and colour classifier. One word is taken at a time.
// A word that does not close a window only writes its sample to the RAM. A word that
// closes a window before every channel has been seen runs through accept, Window + 1
// sample reads, Window + 1 compare passes and the average update. Once every channel
// has been seen a closing word runs through those steps, three divides, the sum of
// squares, the square root, then class and output.
// Window samples sit in one synchronous RAM with a registered read; averages in a
// three-entry register file. Results wait in an output register until taken; a later
// result holds in the class step, and stalls the input, while the previous one waits.
module color_median_smooth_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  cms_stream_if.sink   in_if,
  cms_stream_if.source out_if
);
  import cms_pkg::*;

  cfg_t cfg_q;
  state_e state_q, state_d;
  logic [15:0] mem [MemDepth];
  logic [15:0] rd_q;
  logic [SlotW-1:0] rd_addr;
  logic [FillW-1:0] fill_q [NChan];
  logic [23:0] sm_q [NChan];
  logic [NChan-1:0] seen_q;
  logic [1:0] ch_q;
  logic [15:0] win_q [Window];
  logic [FillW-1:0] idx_q;
  logic [1:0] k_q;
  logic [16:0] lv_q [NChan];
  logic [18:0] sum_q;
  logic [39:0] q_q;
  logic [16:0] mean_q, spread_q;
  logic valid_q;
  out_word_t out_q;
  logic div_start, div_done, sq_start, sq_done;
  logic [16:0] div_lv;
  logic [23:0] div_dvs;
  logic [19:0] root;
  logic [15:0] med;
  logic [33:0] acc;
  logic [20:0] d3;
  logic [20:0] ad;
  logic [41:0] sqr;
  logic [38:0] mean_prod;
  logic [39:0] sp_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{alpha: 8'd128, white_spread_max: 17'd320, white_mean_min: 17'd1600,
                 black_spread_max: 17'd320, black_mean_max: 17'd480};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAlpha:       cfg_q.alpha <= cfg_data_i[7:0];
        RegWhiteSpread: cfg_q.white_spread_max <= cfg_data_i;
        RegWhiteMean:   cfg_q.white_mean_min <= cfg_data_i;
        RegBlackSpread: cfg_q.black_spread_max <= cfg_data_i;
        RegBlackMean:   cfg_q.black_mean_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_q == StIdle);
  wire accept = in_if.valid && in_if.ready && (in_if.data.channel != 2'd3);
  wire [FillW-1:0] fill_cur = fill_q[in_if.data.channel];
  wire [FillW-1:0] wr_slot = (fill_cur >= FillW'(Window)) ? '0 : fill_cur;
  wire [SlotW-1:0] wr_addr = SlotW'(in_if.data.channel * Window + wr_slot);
  assign rd_addr = SlotW'(ch_q * Window + idx_q);

  always_ff @(posedge clk_i) begin
    if (accept) mem[wr_addr] <= in_if.data.period;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept && wr_slot == FillW'(Window - 1)) state_d = StRead;
      StRead:  if (idx_q == FillW'(Window)) state_d = StSort;
      StSort:  if (idx_q == FillW'(Window)) state_d = StEma;
      StEma:   state_d = (seen_q | (3'd1 << ch_q)) == 3'b111 ? StDiv : StIdle;
      StDiv:   if (div_done && k_q == 2'd2) state_d = StSum;
      StSum:   if (k_q == 2'd2) state_d = StSqrt;
      StSqrt:  if (sq_done) state_d = StClass;
      StClass: if (!valid_q) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign div_start = (state_q == StEma && state_d == StDiv) ||
                     (state_q == StDiv && div_done && k_q != 2'd2);
  assign sq_start = state_q == StSum && k_q == 2'd2;
  assign med = win_q[(Window - 1) / 2];
  assign acc = cfg_q.alpha * sm_q[ch_q] + (9'd256 - cfg_q.alpha) * {med, 8'd0} + 34'd128;
  assign d3 = 21'(3 * lv_q[k_q]) - 21'(sum_q);
  assign ad = d3[20] ? -d3 : d3;
  assign sqr = ad * ad;
  assign mean_prod = {20'd0, sum_q} * {19'd0, Recip3};
  assign sp_prod = {20'd0, root} * {20'd0, Recip9};
  // when ch_q is red, its average is written at the same edge the first divide starts
  assign div_dvs = (state_q == StEma) ? ((ch_q == 2'd0) ? acc[31:8] : sm_q[0])
                                      : sm_q[k_q + 2'd1];

  cms_div u_div (.clk_i, .rst_ni, .start_i(div_start), .divisor_i(div_dvs),
    .done_o(div_done), .level_o(div_lv));
  cms_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .rad_i(q_q + sqr[39:0]),
    .done_o(sq_done), .root_o(root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seen_q <= '0;
      valid_q <= 1'b0;
      idx_q <= '0;
      k_q <= '0;
      for (int c = 0; c < NChan; c++) begin
        fill_q[c] <= '0;
        sm_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          k_q <= '0;
          if (accept) begin
            fill_q[in_if.data.channel] <= (wr_slot == FillW'(Window - 1)) ? '0 : wr_slot + 1'b1;
            ch_q <= in_if.data.channel;
          end
        end
        StRead: begin
          // read data of address idx-1 arrives in the cycle after its address
          if (idx_q != '0) win_q[idx_q - 1'b1] <= rd_q;
          idx_q <= (idx_q == FillW'(Window)) ? '0 : idx_q + 1'b1;
        end
        StSort: begin
          // odd-even transposition pass
          for (int i = 0; i + 1 < Window; i++) begin
            if ((i % 2) == (idx_q[0] ? 1 : 0) && win_q[i] > win_q[i + 1]) begin
              win_q[i] <= win_q[i + 1];
              win_q[i + 1] <= win_q[i];
            end
          end
          idx_q <= idx_q + 1'b1;
        end
        StEma: begin
          sm_q[ch_q] <= acc[31:8];
          seen_q[ch_q] <= 1'b1;
          k_q <= '0;
        end
        StDiv: if (div_done) begin
          lv_q[k_q] <= div_lv;
          k_q <= (k_q == 2'd2) ? '0 : k_q + 2'd1;
          if (k_q == 2'd2) sum_q <= 19'(lv_q[0]) + 19'(lv_q[1]) + 19'(div_lv);
          q_q <= '0;
        end
        StSum: begin
          if (k_q != 2'd2) q_q <= q_q + sqr[39:0];
          k_q <= k_q + 2'd1;
          mean_q <= mean_prod[37:21];
        end
        StSqrt: if (sq_done) spread_q <= sp_prod[39:23];
        StClass: if (!valid_q) begin
          out_q.red_level <= lv_q[0];
          out_q.green_level <= lv_q[1];
          out_q.blue_level <= lv_q[2];
          out_q.mean_level <= mean_q;
          out_q.spread_level <= spread_q;
          if (spread_q <= cfg_q.white_spread_max && mean_q >= cfg_q.white_mean_min)
            out_q.colour_class <= ClassWhite;
          else if (spread_q <= cfg_q.black_spread_max && mean_q <= cfg_q.black_mean_max)
            out_q.colour_class <= ClassBlack;
          else
            out_q.colour_class <= ClassOther;
        end
        StOut: valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.data = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> seen_q == 3'b111) else $error("result before all channels seen");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> !valid_q) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.colour_class <= ClassOther) else $error("bad class");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.red_level <= LevelSat) else $error("level over range");
endmodule
